// ===== hdl/unfp_pkg.sv =====
// unfp_pkg: shared types and constants for the UBX navigation frame parser.
// No dependencies; imported by the top level and the parser core.
`timescale 1ns / 1ps

package unfp_pkg;

   localparam logic [7:0] SYNC_1    = 8'hB5;
   localparam logic [7:0] SYNC_2    = 8'h62;
   localparam logic [7:0] NAV_CLASS = 8'h01;
   localparam logic [7:0] ID_POSLLH = 8'h02;
   localparam logic [7:0] ID_STATUS = 8'h03;

   localparam logic [1:0] DONE_NONE   = 2'd0;
   localparam logic [1:0] DONE_POSLLH = 2'd1;
   localparam logic [1:0] DONE_STATUS = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_POSLLH  = 2'd1,
      KIND_STATUS  = 2'd2,
      KIND_PENDING = 2'd3
   } unfp_kind_type;

   typedef struct packed {
      logic [1:0]  msg_done;
      logic [31:0] lat;
      logic [31:0] lon;
      logic [7:0]  fix;
   } unfp_result_type;

endpackage

// ===== hdl/ubx_nav_frame_parser.sv =====
// ubx_nav_frame_parser: top level, input stage, parser core and result register.
// Depends on unfp_pkg, unfp_in_stage and unfp_parser.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_rx_byte[7:0]
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_msg_done, rsp_latitude,
//           |           |                      | rsp_longitude, rsp_fix_type
//
// One beat in, one beat out; a new byte is taken every cycle unless rsp stalls.
// Bytes pass the input register, then the parser step into the result register.
// Synchronous reset clears the frame position, checksum and committed fields.
// A stalled result holds the parser; the input register stalls the req side
// only while it is full and cannot move on.
`timescale 1ns / 1ps

module ubx_nav_frame_parser
   import unfp_pkg::*;
#(
   parameter int POSLLH_FRAME_LEN = 32,
   parameter int STATUS_FRAME_LEN = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_msg_done,
   output logic signed [30:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic [7:0]         rsp_fix_type
);

   logic            s1_valid;
   logic [7:0]      s1_byte;
   logic            advance;
   unfp_result_type result;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      done_ff;
   logic [30:0]     lat_ff;
   logic [31:0]     lon_ff;
   logic [7:0]      fix_ff;

   assign advance = s1_valid && (!rsp_valid_ff || !rsp_stall);

   unfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .s1_valid    (s1_valid),
      .s1_byte     (s1_byte)
   );

   unfp_parser #(
      .POSLLH_FRAME_LEN (POSLLH_FRAME_LEN),
      .STATUS_FRAME_LEN (STATUS_FRAME_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (s1_byte),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         done_ff <= result.msg_done;
         lat_ff  <= result.lat[30:0];
         lon_ff  <= result.lon;
         fix_ff  <= result.fix;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_msg_done  = done_ff;
   assign rsp_latitude  = $signed(lat_ff);
   assign rsp_longitude = $signed(lon_ff);
   assign rsp_fix_type  = fix_ff;

endmodule

// ===== hdl/unfp_in_stage.sv =====
// unfp_in_stage: input register for received bytes with stall generation.
// No dependencies.
`timescale 1ns / 1ps

module unfp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   input  logic       advance,
   output logic       s1_valid,
   output logic [7:0] s1_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_byte  = byte_ff;

endmodule

// ===== hdl/unfp_parser.sv =====
// unfp_parser: frame position, Fletcher checksum, field capture and commit.
// Depends on unfp_pkg for kind codes, done codes and the result struct.
`timescale 1ns / 1ps

module unfp_parser
   import unfp_pkg::*;
#(
   parameter int POSLLH_FRAME_LEN = 32,
   parameter int STATUS_FRAME_LEN = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output unfp_result_type result
);

   localparam int MAX_LEN = (POSLLH_FRAME_LEN > STATUS_FRAME_LEN) ?
                            POSLLH_FRAME_LEN : STATUS_FRAME_LEN;
   localparam int PW = $clog2(MAX_LEN + 4);

   localparam logic [PW-1:0] POS_ONE   = PW'(1);
   localparam logic [PW-1:0] POS_TWO   = PW'(2);
   localparam logic [PW-1:0] IDX_FIX   = PW'(8);
   localparam logic [PW-1:0] IDX_LON   = PW'(8);
   localparam logic [PW-1:0] IDX_LAT   = PW'(12);
   localparam logic [PW-1:0] IDX_END   = PW'(16);
   localparam logic [PW-1:0] LEN_POS   = PW'(POSLLH_FRAME_LEN);
   localparam logic [PW-1:0] LEN_STA   = PW'(STATUS_FRAME_LEN);
   localparam logic [PW-1:0] LEN_POS_1 = PW'(POSLLH_FRAME_LEN + 1);
   localparam logic [PW-1:0] LEN_STA_1 = PW'(STATUS_FRAME_LEN + 1);

   logic [PW-1:0] pos_ff, pos_in;
   unfp_kind_type kind_ff, kind_in;
   logic [7:0]    sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [31:0]   lat_sh_ff, lat_sh_in, lon_sh_ff, lon_sh_in;
   logic [7:0]    fix_sh_ff, fix_sh_in;
   logic [31:0]   lat_ff, lat_in, lon_ff, lon_in;
   logic [7:0]    fix_ff, fix_in;
   logic [1:0]    done;

   logic [PW-1:0] idx, len, len_p1;
   logic          live;

   always_comb begin
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      lat_sh_in = lat_sh_ff;
      lon_sh_in = lon_sh_ff;
      fix_sh_in = fix_sh_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      fix_in    = fix_ff;
      done      = DONE_NONE;
      idx       = pos_ff - POS_TWO;
      live      = 1'b0;
      len       = LEN_STA;
      len_p1    = LEN_STA_1;

      if (pos_ff < POS_TWO) begin
         // sync hunt; a repeated 0xB5 drops back to hunting for the first sync byte
         if (rx_byte == ((pos_ff == '0) ? SYNC_1 : SYNC_2)) begin
            pos_in = pos_ff + POS_ONE;
         end else begin
            pos_in = '0;
         end
      end else begin
         pos_in = pos_ff + POS_ONE;
         live   = 1'b1;
         if (idx == '0) begin
            kind_in  = (rx_byte == NAV_CLASS) ? KIND_PENDING : KIND_NONE;
            sum_a_in = '0;
            sum_b_in = '0;
         end else if (idx == POS_ONE) begin
            if (kind_ff == KIND_PENDING && rx_byte == ID_POSLLH) begin
               kind_in = KIND_POSLLH;
            end else if (kind_ff == KIND_PENDING && rx_byte == ID_STATUS) begin
               kind_in = KIND_STATUS;
            end else begin
               kind_in = KIND_NONE;
               pos_in  = '0;
               live    = 1'b0;
            end
         end

         if (kind_in == KIND_POSLLH) begin
            len    = LEN_POS;
            len_p1 = LEN_POS_1;
         end

         if (live) begin
            if (idx < POS_TWO || idx < len) begin
               sum_a_in = sum_a_in + rx_byte;
               sum_b_in = sum_b_in + sum_a_in;
               if (idx == IDX_FIX) begin
                  fix_sh_in = rx_byte;
               end
               if (idx >= IDX_LON && idx < IDX_LAT) begin
                  lon_sh_in[idx[1:0]*8 +: 8] = rx_byte;
               end
               if (idx >= IDX_LAT && idx < IDX_END) begin
                  lat_sh_in[idx[1:0]*8 +: 8] = rx_byte;
               end
            end else if (idx == len) begin
               if (rx_byte != sum_a_ff) begin
                  pos_in = '0;
               end
            end else begin
               pos_in = '0;
               if (idx == len_p1 && rx_byte == sum_b_ff) begin
                  if (kind_in == KIND_POSLLH) begin
                     lat_in = lat_sh_ff;
                     lon_in = lon_sh_ff;
                     done   = DONE_POSLLH;
                  end else if (kind_in == KIND_STATUS) begin
                     fix_in = fix_sh_ff;
                     done   = DONE_STATUS;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         kind_ff   <= KIND_NONE;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         lat_sh_ff <= '0;
         lon_sh_ff <= '0;
         fix_sh_ff <= '0;
         lat_ff    <= '0;
         lon_ff    <= '0;
         fix_ff    <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         lat_sh_ff <= lat_sh_in;
         lon_sh_ff <= lon_sh_in;
         fix_sh_ff <= fix_sh_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         fix_ff    <= fix_in;
      end
   end

   always_comb begin
      result.msg_done = done;
      result.lat      = lat_in;
      result.lon      = lon_in;
      result.fix      = fix_in;
   end

endmodule
